// ----- hw/rtl/sfp_pkg.sv -----
// Shared types and constants for the sonar frame parser with proximity detection.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  localparam int SensorMax = 7;   // width of the fixed sensor masks
  localparam int ByteW     = 8;
  localparam int SensW     = 3;

  // bytes at or above this value carry a distance
  localparam logic [ByteW-1:0] DistMin = 8'd8;

  localparam int RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_NEAR_MIN      = 3'd0,
    REG_NEAR_MAX      = 3'd1,
    REG_FLOOR_LIMIT   = 3'd2,
    REG_FLOOR_MASK    = 3'd3,
    REG_FLAGGED_ONLY  = 3'd4
  } reg_idx_e;

  localparam logic [ByteW-1:0]     NearMinRst    = 8'd8;
  localparam logic [ByteW-1:0]     NearMaxRst    = 8'd24;
  localparam logic [ByteW-1:0]     FloorLimitRst = 8'd150;
  localparam logic [SensorMax-1:0] FloorMaskRst  = 7'd20;

  typedef struct packed {
    logic [ByteW-1:0]     near_min;
    logic [ByteW-1:0]     near_max;
    logic [ByteW-1:0]     floor_limit;
    logic [SensorMax-1:0] floor_mask;
    logic                 flagged_only;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfp_if.sv -----
// Valid/ready channel interfaces for the sonar frame parser: byte in, result out.
// Depends on sfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfp_byte_if;
  logic                    valid;
  logic                    ready;
  logic [sfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if;
  logic                        valid;
  logic                        ready;
  logic [sfp_pkg::SensorMax-1:0] detect_mask;
  logic                        obstacle;
  logic [sfp_pkg::SensW-1:0]     stored_sensor;
  logic [sfp_pkg::ByteW-1:0]     stored_value;

  modport source (output valid, output detect_mask, output obstacle,
                  output stored_sensor, output stored_value, input ready);
  modport sink   (input valid, input detect_mask, input obstacle,
                  input stored_sensor, input stored_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sonar_frame_parser_proximity_detect_core.sv -----
// Sonar frame parser top level: byte decode, distance store, result register.
// Depends on sfp_pkg, sfp_if (channel interfaces) and sfp_detect.
`timescale 1ns / 1ps
`default_nettype none

// One received byte is taken per clock and yields one result in the cycle
// after; the result register parts input and output, so a new byte is taken
// whenever it is empty or being drained. The cycle is set by the path from the
// stored distances through the flag compare, the lowest pending select and
// the updated-distance compare into the result register. Bytes 1..SENSOR_COUNT
// mark an accepted sensor pending, other bytes below 8 clear the pending set,
// larger bytes store a distance for the lowest accepted pending sensor.
// Registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle (unenforced) and take effect for the next byte.
module sonar_frame_parser_proximity_detect_core #(
  parameter int SENSOR_COUNT = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfp_byte_if.sink                        rx_i,
  sfp_result_if.source                    res_o,
  input  logic                            cfg_we_i,
  input  logic [sfp_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [sfp_pkg::ByteW-1:0]       cfg_data_i
);
  import sfp_pkg::*;

  cfg_t cfg_q;

  logic [SensorMax-1:0] pending_q, pending_d;
  logic [ByteW-1:0]     dist_q [SENSOR_COUNT];
  logic [ByteW-1:0]     dist_d [SENSOR_COUNT];

  logic                 out_valid_q;
  logic [SensorMax-1:0] detect_q;
  logic                 obstacle_q;
  logic [SensW-1:0]     sensor_q, sensor_d;
  logic [ByteW-1:0]     value_q, value_d;

  logic                 in_ready, in_take;
  logic [SensorMax-1:0] valid_mask, flags, accept, cand, lowest, detect_d;
  logic [ByteW-1:0]     num_hot;
  logic                 is_num, do_store;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_min     <= NearMinRst;
      cfg_q.near_max     <= NearMaxRst;
      cfg_q.floor_limit  <= FloorLimitRst;
      cfg_q.floor_mask   <= FloorMaskRst;
      cfg_q.flagged_only <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NEAR_MIN:     cfg_q.near_min     <= cfg_data_i;
        REG_NEAR_MAX:     cfg_q.near_max     <= cfg_data_i;
        REG_FLOOR_LIMIT:  cfg_q.floor_limit  <= cfg_data_i;
        REG_FLOOR_MASK:   cfg_q.floor_mask   <= cfg_data_i[SensorMax-1:0];
        REG_FLAGGED_ONLY: cfg_q.flagged_only <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- decode ----------------
  sfp_detect #(.SENSOR_COUNT(SENSOR_COUNT)) u_flags (
    .dist_i (dist_q),
    .cfg_i  (cfg_q),
    .mask_o (flags)
  );

  assign in_ready = !out_valid_q || res_o.ready;
  assign in_take  = rx_i.valid && in_ready;
  assign rx_i.ready = in_ready;

  always_comb begin
    for (int k = 0; k < SensorMax; k++) begin
      valid_mask[k] = (k < SENSOR_COUNT);
    end
  end

  assign accept  = cfg_q.flagged_only ? flags : valid_mask;
  assign is_num  = rx_i.rx_byte < DistMin;
  // bit 0 stands for number zero and is dropped
  assign num_hot = ByteW'(1) << rx_i.rx_byte[SensW-1:0];
  assign cand    = pending_q & accept;
  assign lowest  = cand & (~cand + SensorMax'(1));
  assign do_store = !is_num && (cand != '0);

  always_comb begin
    pending_d = pending_q;
    sensor_d  = '0;
    value_d   = '0;
    if (is_num) begin
      if ((num_hot[SensorMax:1] & accept) != '0) begin
        pending_d = pending_q | num_hot[SensorMax:1];
      end else begin
        pending_d = '0;
      end
    end else if (do_store) begin
      pending_d = '0;
      value_d   = rx_i.rx_byte;
      for (int k = 0; k < SensorMax; k++) begin
        if (lowest[k]) begin
          sensor_d = SensW'(k + 1);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      dist_d[k] = (do_store && lowest[k]) ? rx_i.rx_byte : dist_q[k];
    end
  end

  sfp_detect #(.SENSOR_COUNT(SENSOR_COUNT)) u_detect (
    .dist_i (dist_d),
    .cfg_i  (cfg_q),
    .mask_o (detect_d)
  );

  // ---------------- state and result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        dist_q[k] <= '0;
      end
    end else if (in_take) begin
      pending_q <= pending_d;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        dist_q[k] <= dist_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      detect_q   <= detect_d;
      obstacle_q <= |detect_d[5:1];
      sensor_q   <= sensor_d;
      value_q    <= value_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.detect_mask   = detect_q;
  assign res_o.obstacle      = obstacle_q;
  assign res_o.stored_sensor = sensor_q;
  assign res_o.stored_value  = value_q;

  // ---------------- assertions ----------------
  a_store_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && do_store |=> pending_q == '0)
    else $error("pending set survived a stored distance");

  a_store_is_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sensor_q != '0 |-> value_q >= DistMin)
    else $error("stored value below distance range");

  a_no_store_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sensor_q == '0 |-> value_q == '0)
    else $error("value reported without a stored sensor");

  a_detect_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (detect_q & ~valid_mask) == '0)
    else $error("detect bit set for an absent sensor");

  a_pending_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~valid_mask) == '0)
    else $error("pending bit set for an absent sensor");

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_detect.sv -----
// Per-sensor proximity compare: wall window or floor limit on each stored distance.
// Depends on sfp_pkg (cfg_t, widths).
`timescale 1ns / 1ps
`default_nettype none

module sfp_detect #(
  parameter int SENSOR_COUNT = 7
) (
  input  logic [sfp_pkg::ByteW-1:0]     dist_i [SENSOR_COUNT],
  input  sfp_pkg::cfg_t                 cfg_i,
  output logic [sfp_pkg::SensorMax-1:0] mask_o
);
  import sfp_pkg::*;

  for (genvar k = 0; k < SensorMax; k++) begin : g_sens
    if (k < SENSOR_COUNT) begin : g_on
      logic floor_hit, wall_hit;
      assign floor_hit = dist_i[k] > cfg_i.floor_limit;
      assign wall_hit  = (dist_i[k] >= cfg_i.near_min) && (dist_i[k] < cfg_i.near_max);
      assign mask_o[k] = cfg_i.floor_mask[k] ? floor_hit : wall_hit;
    end else begin : g_off
      assign mask_o[k] = 1'b0;
    end
  end

endmodule

`default_nettype wire
